/* rtl/slcc_pkg.sv */
// Package for the signal lamp conflict check unit: transaction structs, lamp codes,
// reject reasons and the fixed phase tables.
// No dependencies.
`default_nettype none

package slcc_pkg;

   localparam int MOVEMENTS = 8;
   localparam int CROSSINGS = 4;

   typedef logic [1:0] lamp_code_type;
   typedef logic [1:0] phase_type;
   typedef logic [1:0] reason_type;

   localparam lamp_code_type VEH_AMBER  = 2'd1;
   localparam lamp_code_type VEH_GREEN  = 2'd2;
   localparam lamp_code_type WALK_ON    = 2'd1;
   localparam lamp_code_type WALK_FLASH = 2'd2;

   localparam reason_type REASON_NONE     = 2'd0;
   localparam reason_type REASON_RAIL     = 2'd1;
   localparam reason_type REASON_CONFLICT = 2'd2;

   localparam phase_type PHASE_A = 2'd0;
   localparam phase_type PHASE_B = 2'd1;
   localparam phase_type PHASE_C = 2'd2;
   localparam phase_type PHASE_D = 2'd3;

   typedef struct packed {
      logic [15:0] vehicle_lamps;
      logic [7:0]  walker_lamps;
      logic [7:0]  blocked_mask;
   } slcc_req_type;

   typedef struct packed {
      logic       safe;
      reason_type reject_reason;
   } slcc_rsp_type;

   // Vehicle movements run A,A,C,C,B,B,D,D.
   function automatic phase_type veh_phase(input logic [2:0] idx);
      phase_type p;
      case (idx)
         3'd0, 3'd1: p = PHASE_A;
         3'd2, 3'd3: p = PHASE_C;
         3'd4, 3'd5: p = PHASE_B;
         default:    p = PHASE_D;
      endcase
      return p;
   endfunction

   // Pedestrian crossings run C,C,A,A.
   function automatic phase_type walk_phase(input logic [1:0] idx);
      phase_type p;
      case (idx)
         2'd0, 2'd1: p = PHASE_C;
         default:    p = PHASE_A;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

/* rtl/slcc_verdict.sv */
// Combinational verdict for one lamp snapshot: rail entry and phase conflict checks.
// Depends on slcc_pkg.
`default_nettype none

module slcc_verdict
   import slcc_pkg::*;
(
   input  slcc_req_type snap,
   output slcc_rsp_type verdict
);

   logic          have;
   logic          done;
   phase_type     allowed;
   reason_type    reason;
   lamp_code_type code;

   // Scan vehicles in index order, then pedestrians; the first rejection found wins.
   always_comb begin
      have    = 1'b0;
      done    = 1'b0;
      allowed = PHASE_A;
      reason  = REASON_NONE;
      code    = '0;
      for (int i = 0; i < MOVEMENTS; i++) begin
         code = snap.vehicle_lamps[2*i +: 2];
         if (!done && (code == VEH_GREEN || code == VEH_AMBER)) begin
            // A green into a blocked arm is checked before the phase test.
            if (snap.blocked_mask[i] && code == VEH_GREEN) begin
               done   = 1'b1;
               reason = REASON_RAIL;
            end else if (!have) begin
               have    = 1'b1;
               allowed = veh_phase(3'(i));
            end else if (allowed != veh_phase(3'(i))) begin
               done   = 1'b1;
               reason = REASON_CONFLICT;
            end
         end
      end
      for (int j = 0; j < CROSSINGS; j++) begin
         code = snap.walker_lamps[2*j +: 2];
         if (!done && (code == WALK_ON || code == WALK_FLASH)) begin
            if (!have) begin
               have    = 1'b1;
               allowed = walk_phase(2'(j));
            end else if (allowed != walk_phase(2'(j))) begin
               done   = 1'b1;
               reason = REASON_CONFLICT;
            end
         end
      end
      verdict.safe          = !done;
      verdict.reject_reason = reason;
   end

endmodule

`default_nettype wire

/* rtl/signal_lamp_conflict_check_unit.sv */
// Channel | Direction | Handshake            | Payload
// req_    | in        | req_valid/req_ready  | slcc_req_type: vehicle, walker lamps, blocked mask
// rsp_    | out       | rsp_valid/rsp_ready  | slcc_rsp_type: safe, reject_reason
//
// One transaction per cycle unless rsp_ready stalls; each verdict is registered as the result.
// Latency is set by the request register and the result register around the verdict logic.
// Synchronous active-high reset clears both valid flags; payload registers are not reset.
// A stall on rsp_ready holds the result; the request stage keeps accepting until it is full.
// Depends on slcc_pkg and slcc_verdict.
`default_nettype none

module signal_lamp_conflict_check_unit
   import slcc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  slcc_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output slcc_rsp_type rsp_data
);

   logic         req_valid_ff, req_valid_in;
   slcc_req_type req_data_ff, req_data_in;
   logic         rsp_valid_ff, rsp_valid_in;
   slcc_rsp_type rsp_data_ff, rsp_data_in;
   slcc_rsp_type verdict;
   logic         rsp_load;
   logic         req_load;

   slcc_verdict u_verdict (
      .snap    (req_data_ff),
      .verdict (verdict)
   );

   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign req_load  = !req_valid_ff || rsp_load;
   assign req_ready = req_load;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_data_in  = req_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = req_valid_ff;
         rsp_data_in  = verdict;
      end
      if (req_load) begin
         req_valid_in = req_valid;
         req_data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_safe_matches_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.safe == (rsp_data_ff.reject_reason == REASON_NONE)))
      else $error("safe flag disagrees with reject reason");

   a_reason_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.reject_reason == REASON_NONE ||
                        rsp_data_ff.reject_reason == REASON_RAIL ||
                        rsp_data_ff.reject_reason == REASON_CONFLICT))
      else $error("undefined reject reason on a valid result");

   a_request_advances: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("held request did not move into a free result register");
`endif

endmodule

`default_nettype wire

/* test/signal_lamp_conflict_check_unit_tb.sv */
// Self-checking testbench for signal_lamp_conflict_check_unit: directed corner snapshots,
// then random lamp snapshots, with every verdict compared against an in-bench predictor.
// Depends on slcc_pkg and the unit under test.
`timescale 1ns / 1ps

module signal_lamp_conflict_check_unit_tb;
   import slcc_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int CYCLE_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 8;

   // Phase of each vehicle movement and each crossing, two bits per entry, index 0 lowest.
   localparam logic [15:0] MOVE_PHASES =
      {PHASE_D, PHASE_D, PHASE_B, PHASE_B, PHASE_C, PHASE_C, PHASE_A, PHASE_A};
   localparam logic [7:0] CROSS_PHASES = {PHASE_A, PHASE_A, PHASE_C, PHASE_C};

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   slcc_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   slcc_rsp_type rsp_data;

   slcc_req_type pending_snapshots[$];
   slcc_rsp_type expected_verdicts[$];
   slcc_rsp_type want;

   int cycle_count = 0;
   int failures    = 0;
   int n_checked   = 0;
   int n_safe      = 0;
   int n_rail      = 0;
   int n_conflict  = 0;

   // Both sides run without idling inside this window.
   wire steady = (cycle_count >= 150) && (cycle_count < 350);

   signal_lamp_conflict_check_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic slcc_rsp_type lamp_verdict(input slcc_req_type snap);
      slcc_rsp_type  v;
      logic          have;
      logic          done;
      phase_type     allowed;
      lamp_code_type code;
      int            i;
      v.safe          = 1'b1;
      v.reject_reason = REASON_NONE;
      have            = 1'b0;
      done            = 1'b0;
      allowed         = PHASE_A;
      for (i = 0; i < MOVEMENTS; i++) begin
         code = snap.vehicle_lamps[2*i +: 2];
         if (!done && (code == VEH_GREEN || code == VEH_AMBER)) begin
            // A green into a blocked arm is caught before the phase comparison.
            if (snap.blocked_mask[i] && code == VEH_GREEN) begin
               v.safe          = 1'b0;
               v.reject_reason = REASON_RAIL;
               done            = 1'b1;
            end else if (!have) begin
               have    = 1'b1;
               allowed = MOVE_PHASES[2*i +: 2];
            end else if (allowed != MOVE_PHASES[2*i +: 2]) begin
               v.safe          = 1'b0;
               v.reject_reason = REASON_CONFLICT;
               done            = 1'b1;
            end
         end
      end
      for (i = 0; i < CROSSINGS; i++) begin
         code = snap.walker_lamps[2*i +: 2];
         if (!done && (code == WALK_ON || code == WALK_FLASH)) begin
            if (!have) begin
               have    = 1'b1;
               allowed = CROSS_PHASES[2*i +: 2];
            end else if (allowed != CROSS_PHASES[2*i +: 2]) begin
               v.safe          = 1'b0;
               v.reject_reason = REASON_CONFLICT;
               done            = 1'b1;
            end
         end
      end
      return v;
   endfunction

   function automatic void queue_snapshot(input logic [15:0] veh, input logic [7:0] walk,
                                          input logic [7:0] blk);
      slcc_req_type s;
      s.vehicle_lamps = veh;
      s.walker_lamps  = walk;
      s.blocked_mask  = blk;
      pending_snapshots.push_back(s);
   endfunction

   // Mostly one phase lit with random codes, others dark, and an occasional stray lamp.
   function automatic slcc_req_type random_phase_snapshot();
      slcc_req_type s;
      phase_type    p;
      int           i;
      p = phase_type'($urandom_range(3));
      for (i = 0; i < MOVEMENTS; i++) begin
         if (MOVE_PHASES[2*i +: 2] == p)
            s.vehicle_lamps[2*i +: 2] = lamp_code_type'($urandom_range(3));
         else if ($urandom_range(99) < 5)
            s.vehicle_lamps[2*i +: 2] = lamp_code_type'($urandom_range(2, 1));
         else
            s.vehicle_lamps[2*i +: 2] = $urandom_range(1) ? 2'd3 : 2'd0;
      end
      for (i = 0; i < CROSSINGS; i++) begin
         if (CROSS_PHASES[2*i +: 2] == p)
            s.walker_lamps[2*i +: 2] = lamp_code_type'($urandom_range(3));
         else if ($urandom_range(99) < 5)
            s.walker_lamps[2*i +: 2] = lamp_code_type'($urandom_range(2, 1));
         else
            s.walker_lamps[2*i +: 2] = $urandom_range(1) ? 2'd3 : 2'd0;
      end
      case ($urandom_range(2))
         0:       s.blocked_mask = 8'h00;
         1:       s.blocked_mask = 8'($urandom & $urandom & $urandom);
         default: s.blocked_mask = 8'($urandom);
      endcase
      return s;
   endfunction

   // Driver: a new transaction is offered only once the previous one has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_snapshots.size() > 0 && (steady || $urandom_range(99) >= 20)) begin
            req_data  <= pending_snapshots.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: records the verdict of each accepted request and checks each result.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_verdicts.push_back(lamp_verdict(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("Result with no request outstanding: safe=%0d reject_reason=%0d",
                      rsp_data.safe, rsp_data.reject_reason);
               failures++;
            end else begin
               want = expected_verdicts.pop_front();
               n_checked++;
               if (want.safe)
                  n_safe++;
               else if (want.reject_reason == REASON_RAIL)
                  n_rail++;
               else
                  n_conflict++;
               if (rsp_data.safe !== want.safe) begin
                  $error("Field safe: expected %0d, actual %0d", want.safe, rsp_data.safe);
                  failures++;
               end
               if (rsp_data.reject_reason !== want.reject_reason) begin
                  $error("Field reject_reason: expected %0d, actual %0d",
                         want.reject_reason, rsp_data.reject_reason);
                  failures++;
               end
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= 20);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int n;
      // Extremes of every field.
      queue_snapshot(16'h0000, 8'h00, 8'h00);
      queue_snapshot(16'hFFFF, 8'hFF, 8'hFF);
      queue_snapshot(16'hFFFF, 8'hFF, 8'h00);
      queue_snapshot(16'hAAAA, 8'hAA, 8'h00);
      queue_snapshot(16'h5555, 8'h55, 8'hFF);
      queue_snapshot(16'hAAAA, 8'h00, 8'hFF);
      // Green into a blocked arm, and amber on a blocked arm, which is not a rail entry.
      queue_snapshot(16'h0200, 8'h00, 8'h10);
      queue_snapshot(16'h0100, 8'h00, 8'h10);
      queue_snapshot(16'h8000, 8'h00, 8'h80);
      // Rail entry found first beats a later conflict; an earlier conflict beats a rail entry.
      queue_snapshot(16'h0022, 8'h00, 8'h01);
      queue_snapshot(16'h0222, 8'h00, 8'h10);
      // Same-phase pairs are safe; cross-phase pairs conflict.
      queue_snapshot(16'h0006, 8'h00, 8'h00);
      queue_snapshot(16'h0012, 8'h00, 8'h00);
      queue_snapshot(16'h0002, 8'h20, 8'h00);
      queue_snapshot(16'h0002, 8'h01, 8'h00);
      queue_snapshot(16'h0000, 8'h11, 8'h00);
      queue_snapshot(16'h0000, 8'h06, 8'h00);
      queue_snapshot(16'h00A0, 8'h05, 8'h00);
      // Code "other" is dark for vehicles and walkers alike.
      queue_snapshot(16'h0033, 8'h03, 8'h03);
      queue_snapshot(16'hC002, 8'hC0, 8'hFF);
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(99) < 65)
            pending_snapshots.push_back(random_phase_snapshot());
         else
            queue_snapshot(16'($urandom), 8'($urandom), 8'($urandom));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_snapshots.size() > 0 || req_valid || expected_verdicts.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Checked %0d lamp snapshots: %0d safe, %0d rail entry, %0d phase conflict.",
               n_checked, n_safe, n_rail, n_conflict);
      $display("Directed corners, then mostly single-phase snapshots with stray lamps.");
      if (failures == 0 && expected_verdicts.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
